// File: hw/rtl/srfch_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the SPI relay frame handler.
`timescale 1ns / 1ps

package srfch_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_SECOND = 8'd1;

   localparam int RELAY_OUT_W = 5;

   // Per-frame summary handed from front to back
   typedef struct packed {
      logic [15:0]            crc;
      logic                   crc_ok;
      logic [RELAY_OUT_W-1:0] relay;
   } frame_desc_type;

   // One byte of reflected CRC-16 (poly 0xA001), eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/srfch_front.sv
// Front end: accepts received bytes, tracks frame position, runs the CRC and builds frame summaries.
`timescale 1ns / 1ps

module srfch_front
   import srfch_pkg::*;
#(
   parameter int FRAME_BYTES = 8,
   parameter int RELAY_COUNT = 5,
   parameter int POS_W       = 3,
   parameter int PADDR_W     = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [7:0]         req_rx_byte,
   input  logic               full,
   input  logic [7:0]         match_first,
   input  logic [7:0]         match_second,
   output logic               wr_en,
   output logic [PADDR_W-1:0] wr_addr,
   output logic [7:0]         wr_data,
   output logic               push_desc,
   output frame_desc_type     desc
);

   localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
   localparam logic [POS_W-1:0] POS_LAST_PAY = POS_W'(PAYLOAD_BYTES - 1);
   localparam logic [POS_W-1:0] POS_CRC_HI   = POS_W'(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_FIRST    = '0;
   localparam logic [POS_W-1:0] POS_SECOND   = POS_W'(1);

   logic                   accept;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             byte0_ff, byte0_in;
   logic [7:0]             byte1_ff, byte1_in;
   logic [7:0]             rx_hi_ff, rx_hi_in;
   logic [RELAY_COUNT-1:0] relay_src_ff, relay_src_in;
   logic [RELAY_COUNT-1:0] relay_ff, relay_in;
   logic                   is_payload;
   logic                   is_last;
   logic                   match;
   logic [RELAY_COUNT+RELAY_OUT_W-1:0] relay_wide;

   assign accept     = req_push & ~full;
   assign is_payload = (pos_ff < POS_CRC_HI);
   assign is_last    = (pos_ff == POS_LAST);
   assign match      = (byte0_ff == match_first) && (byte1_ff == match_second);

   // Write payload bytes into the open bank
   assign wr_en   = accept & is_payload;
   assign wr_addr = pos_ff[PADDR_W-1:0];
   assign wr_data = req_rx_byte;

   // Advance position, CRC and captured bytes
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      byte0_in     = byte0_ff;
      byte1_in     = byte1_ff;
      rx_hi_in     = rx_hi_ff;
      relay_src_in = relay_src_ff;
      relay_in     = relay_ff;
      if (accept) begin
         if (pos_ff == POS_FIRST) begin
            byte0_in = req_rx_byte;
         end
         if (pos_ff == POS_SECOND) begin
            byte1_in = req_rx_byte;
         end
         if (pos_ff == POS_LAST_PAY) begin
            relay_src_in = req_rx_byte[RELAY_COUNT-1:0];
         end
         if (pos_ff == POS_CRC_HI) begin
            rx_hi_in = req_rx_byte;
         end
         if (is_payload) begin
            crc_in = crc_byte(crc_ff, req_rx_byte);
         end
         if (is_last) begin
            pos_in = '0;
            crc_in = CRC_INIT;
            if (match) begin
               relay_in = relay_src_ff;
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // Close the frame on its last byte
   assign relay_wide     = {{RELAY_OUT_W{1'b0}}, relay_in};
   assign push_desc      = accept & is_last;
   assign desc.crc       = crc_ff;
   assign desc.crc_ok    = ({rx_hi_ff, req_rx_byte} == crc_ff);
   assign desc.relay     = relay_wide[RELAY_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         crc_ff   <= CRC_INIT;
         rx_hi_ff <= '0;
         relay_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         rx_hi_ff <= rx_hi_in;
         relay_ff <= relay_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff     <= byte0_in;
      byte1_ff     <= byte1_in;
      relay_src_ff <= relay_src_in;
   end

endmodule

// File: hw/rtl/srfch_frame_queue.sv
// Two-frame queue: ping-pong payload banks and frame summaries between front and back.
`timescale 1ns / 1ps

module srfch_frame_queue
   import srfch_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 6,
   parameter int PADDR_W       = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [PADDR_W-1:0] wr_addr,
   input  logic [7:0]         wr_data,
   input  logic               push_desc,
   input  frame_desc_type     desc_in,
   input  logic               pop_desc,
   input  logic [PADDR_W-1:0] rd_addr,
   output logic [7:0]         rd_data,
   output frame_desc_type     desc_out,
   output logic               avail,
   output logic               full
);

   logic [7:0]     bank_ff [2][PAYLOAD_BYTES];
   frame_desc_type desc_ff [2];
   logic           wr_sel_ff, wr_sel_in;
   logic           rd_sel_ff, rd_sel_in;
   logic [1:0]     count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign avail    = (count_ff != 2'd0);
   assign rd_data  = bank_ff[rd_sel_ff][rd_addr];
   assign desc_out = desc_ff[rd_sel_ff];

   // Store payload bytes and frame summaries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_ff[wr_sel_ff][wr_addr] <= wr_data;
      end
      if (push_desc) begin
         desc_ff[wr_sel_ff] <= desc_in;
      end
   end

   // Track bank ownership and occupancy
   always_comb begin
      wr_sel_in = wr_sel_ff ^ push_desc;
      rd_sel_in = rd_sel_ff ^ pop_desc;
      count_in  = count_ff + {1'b0, push_desc} - {1'b0, pop_desc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_sel_ff <= wr_sel_in;
         rd_sel_ff <= rd_sel_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/srfch_back.sv
// Back end: walks a queued frame and presents its response bytes on the result queue.
`timescale 1ns / 1ps

module srfch_back
   import srfch_pkg::*;
#(
   parameter int FRAME_BYTES = 8,
   parameter int POS_W       = 3,
   parameter int PADDR_W     = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   avail,
   input  frame_desc_type         desc,
   input  logic [7:0]             rd_data,
   output logic [PADDR_W-1:0]     rd_addr,
   output logic                   pop_desc,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last_of_frame,
   output logic                   rsp_crc_ok,
   output logic [RELAY_OUT_W-1:0] rsp_relay_outputs
);

   localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
   localparam logic [POS_W-1:0] IDX_CRC_HI = POS_W'(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] IDX_LAST   = POS_W'(FRAME_BYTES - 1);

   logic [POS_W-1:0] idx_ff, idx_in;
   logic             transfer;
   logic             in_payload;

   assign in_payload = (idx_ff < IDX_CRC_HI);
   assign rd_addr    = in_payload ? idx_ff[PADDR_W-1:0] : '0;

   // Select the response byte for the current index
   always_comb begin
      if (in_payload) begin
         rsp_tx_byte = rd_data;
      end else if (idx_ff == IDX_CRC_HI) begin
         rsp_tx_byte = desc.crc[15:8];
      end else begin
         rsp_tx_byte = desc.crc[7:0];
      end
   end

   assign rsp_empty         = ~avail;
   assign rsp_last_of_frame = (idx_ff == IDX_LAST);
   assign rsp_crc_ok        = desc.crc_ok;
   assign rsp_relay_outputs = desc.relay;

   // Advance on each transfer, release the frame after its last byte
   assign transfer = rsp_pop & avail;
   assign pop_desc = transfer & rsp_last_of_frame;

   always_comb begin
      idx_in = idx_ff;
      if (transfer) begin
         idx_in = rsp_last_of_frame ? '0 : idx_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: hw/rtl/spi_relay_frame_crc_handler.sv
// Top level of the SPI relay frame handler with CRC-16/MODBUS check.
// Throughput: one received byte and one response byte per cycle unless req_full or rsp_empty.
// The summary of a frame is registered on its last byte; its response waits for earlier frames.
// The two-frame payload queue sets the slack: the next frame is taken in while one drains.
// Reset (synchronous): relays off, CRC at 0xFFFF, position zero, queue empty, match regs at 1.
`timescale 1ns / 1ps

module spi_relay_frame_crc_handler
   import srfch_pkg::*;
#(
   parameter int FRAME_BYTES = 8,
   parameter int RELAY_COUNT = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last_of_frame,
   output logic                   rsp_crc_ok,
   output logic [RELAY_OUT_W-1:0] rsp_relay_outputs,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
   localparam int POS_W         = $clog2(FRAME_BYTES);
   localparam int PADDR_W       = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   logic [7:0]         match_first_ff, match_first_in;
   logic [7:0]         match_second_ff, match_second_in;
   logic               wr_en;
   logic [PADDR_W-1:0] wr_addr;
   logic [7:0]         wr_data;
   logic               push_desc;
   frame_desc_type     desc_wr;
   frame_desc_type     desc_rd;
   logic               pop_desc;
   logic [PADDR_W-1:0] rd_addr;
   logic [7:0]         rd_data;
   logic               avail;
   logic               full;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      match_first_in  = match_first_ff;
      match_second_in = match_second_ff;
      if (csr_valid) begin
         if (csr_index == CSR_MATCH_FIRST) begin
            match_first_in = csr_data;
         end
         if (csr_index == CSR_MATCH_SECOND) begin
            match_second_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_first_ff  <= 8'd1;
         match_second_ff <= 8'd1;
      end else begin
         match_first_ff  <= match_first_in;
         match_second_ff <= match_second_in;
      end
   end

   assign req_full = full;

   srfch_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .RELAY_COUNT (RELAY_COUNT),
      .POS_W       (POS_W),
      .PADDR_W     (PADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_rx_byte  (req_rx_byte),
      .full         (full),
      .match_first  (match_first_ff),
      .match_second (match_second_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .push_desc    (push_desc),
      .desc         (desc_wr)
   );

   srfch_frame_queue #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .PADDR_W       (PADDR_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push_desc (push_desc),
      .desc_in   (desc_wr),
      .pop_desc  (pop_desc),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .desc_out  (desc_rd),
      .avail     (avail),
      .full      (full)
   );

   srfch_back #(
      .FRAME_BYTES (FRAME_BYTES),
      .POS_W       (POS_W),
      .PADDR_W     (PADDR_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .avail             (avail),
      .desc              (desc_rd),
      .rd_data           (rd_data),
      .rd_addr           (rd_addr),
      .pop_desc          (pop_desc),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_crc_ok        (rsp_crc_ok),
      .rsp_relay_outputs (rsp_relay_outputs)
   );

   // A full queue always has a frame to drain
   assert property (@(posedge clock) disable iff (reset) req_full |-> !rsp_empty)
      else $error("queue full with no frame to drain");

   // A frame stays presented until its last byte transfers
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_of_frame) |=> !rsp_empty)
      else $error("frame vanished before its last byte");

   // Frame status holds across the bytes of one frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_of_frame) |=>
         ($stable(rsp_crc_ok) && $stable(rsp_relay_outputs)))
      else $error("frame status changed mid-frame");

endmodule

// File: dv/tb.sv
// Self-checking bench for the SPI relay frame handler: frame echo, CRC verdict and relays.
`timescale 1ns / 1ps

module tb
   import srfch_pkg::*;
();

   localparam int FRAME_LEN    = 8;
   localparam int PAYLOAD_LEN  = FRAME_LEN - 2;
   localparam int SETTLE_CYC   = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int FRAMES_PER_PHASE = 11;

   // Indexes outside the register map; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 8'hFF;

   typedef struct packed {
      logic [7:0]             tx;
      logic                   last;
      logic                   ok;
      logic [RELAY_OUT_W-1:0] relay;
   } echo_byte_type;

   typedef struct {
      logic [7:0] data;
      bit         wait_drain;
   } spi_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [7:0]             rsp_tx_byte;
   logic                   rsp_last_of_frame;
   logic                   rsp_crc_ok;
   logic [RELAY_OUT_W-1:0] rsp_relay_outputs;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data = 8'h00;

   spi_relay_frame_crc_handler u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_crc_ok        (rsp_crc_ok),
      .rsp_relay_outputs (rsp_relay_outputs),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Shadow of the block state
   logic [7:0]             want_first = 8'd1;
   logic [7:0]             want_second = 8'd1;
   logic [7:0]             shadow_payload [PAYLOAD_LEN];
   logic [15:0]            shadow_crc = CRC_INIT;
   logic [15:0]            shadow_rcv_crc = 16'h0000;
   int                     frame_pos = 0;
   logic [RELAY_OUT_W-1:0] shadow_relay = '0;

   echo_byte_type echo_due [$];
   spi_byte_type  spi_bytes_pending [$];

   int mismatch_count = 0;
   int bytes_taken = 0;
   int bytes_seen = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   bit bus_free;

   initial begin
      forever #5 clock = ~clock;
   end

   // Reflected CRC-16 update, one byte, LSB first
   function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      repeat (8) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // Advance the shadow by one received byte; queue the echo at frame end
   task automatic take_spi_byte(input logic [7:0] b);
      logic ok;
      echo_byte_type e;
      if (frame_pos < PAYLOAD_LEN) begin
         shadow_payload[frame_pos] = b;
         shadow_crc = modbus_crc_step(shadow_crc, b);
         frame_pos++;
      end else if (frame_pos == PAYLOAD_LEN) begin
         shadow_rcv_crc = {b, 8'h00};
         frame_pos++;
      end else begin
         shadow_rcv_crc[7:0] = b;
         ok = (shadow_rcv_crc == shadow_crc);
         // relays follow the address match even on a bad CRC
         if (shadow_payload[0] == want_first && shadow_payload[1] == want_second) begin
            shadow_relay = shadow_payload[PAYLOAD_LEN-1][RELAY_OUT_W-1:0];
         end
         for (int k = 0; k < FRAME_LEN; k++) begin
            if (k < PAYLOAD_LEN) begin
               e.tx = shadow_payload[k];
            end else if (k == PAYLOAD_LEN) begin
               e.tx = shadow_crc[15:8];
            end else begin
               e.tx = shadow_crc[7:0];
            end
            e.last  = (k == FRAME_LEN - 1);
            e.ok    = ok;
            e.relay = shadow_relay;
            echo_due.push_back(e);
         end
         shadow_crc = CRC_INIT;
         frame_pos = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int exp);
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, exp);
      mismatch_count++;
   endtask

   // Queue one frame; crc_flip corrupts the received CRC, hold waits for a drained pipe
   task automatic queue_frame(input logic [47:0] payload, input logic [15:0] crc_flip,
                              input bit hold);
      logic [15:0] crc;
      logic [15:0] sent;
      spi_byte_type s;
      crc = CRC_INIT;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         crc = modbus_crc_step(crc, payload[i*8 +: 8]);
      end
      sent = crc ^ crc_flip;
      for (int i = 0; i < FRAME_LEN; i++) begin
         if (i < PAYLOAD_LEN) begin
            s.data = payload[i*8 +: 8];
         end else if (i == PAYLOAD_LEN) begin
            s.data = sent[15:8];
         end else begin
            s.data = sent[7:0];
         end
         s.wait_drain = hold && (i == 0);
         spi_bytes_pending.push_back(s);
      end
   endtask

   // Mostly addressed frames; the rest partial matches or noise; CRCs mostly good, some bad
   task automatic queue_random_frame(input bit hold);
      logic [47:0] payload;
      logic [15:0] flip;
      int kind;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         case ($urandom_range(9))
            0: payload[i*8 +: 8] = 8'h00;
            1: payload[i*8 +: 8] = 8'hFF;
            default: payload[i*8 +: 8] = 8'($urandom_range(255));
         endcase
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
         payload[7:0]  = want_first;
         payload[15:8] = want_second;
      end else if (kind < 70) begin
         payload[7:0]  = want_first;
      end else if (kind < 80) begin
         payload[15:8] = want_second;
      end
      flip = 16'h0000;
      if ($urandom_range(99) < 30) begin
         flip = 16'($urandom_range(16'hFFFF, 1));
      end
      queue_frame(payload, flip, hold);
   endtask

   task automatic write_match_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      // out-of-range indexes are ignored
      if (idx == CSR_MATCH_FIRST) begin
         want_first = data;
      end else if (idx == CSR_MATCH_SECOND) begin
         want_second = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (spi_bytes_pending.size() != 0 || req_push || echo_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic run_random_phase(input int send_pct, input int pop_pct, input bit hold_mid);
      send_idle_pct = send_pct;
      pop_stall_pct = pop_pct;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
         queue_random_frame(hold_mid && (f == FRAMES_PER_PHASE / 2));
      end
      wait_idle();
   endtask

   // Drive the request side and the pop strobe on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         bus_free = !req_push || (bytes_taken != bytes_seen);
         bytes_seen = bytes_taken;
         if (bus_free) begin
            if (spi_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(spi_bytes_pending[0].wait_drain && echo_due.size() != 0)) begin
               req_push    <= 1'b1;
               req_rx_byte <= spi_bytes_pending[0].data;
               void'(spi_bytes_pending.pop_front());
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Sample transfers on the rising edge: check echoes, then feed the shadow
   always @(posedge clock) begin
      echo_byte_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (echo_due.size() == 0) begin
               report_mismatch("unexpected response tx_byte", rsp_tx_byte, 0);
            end else begin
               e = echo_due.pop_front();
               if (rsp_tx_byte !== e.tx) begin
                  report_mismatch("tx_byte", rsp_tx_byte, e.tx);
               end
               if (rsp_last_of_frame !== e.last) begin
                  report_mismatch("last_of_frame", rsp_last_of_frame, e.last);
               end
               if (rsp_crc_ok !== e.ok) begin
                  report_mismatch("crc_ok", rsp_crc_ok, e.ok);
               end
               if (rsp_relay_outputs !== e.relay) begin
                  report_mismatch("relay_outputs", rsp_relay_outputs, e.relay);
               end
            end
         end
         if (req_push && !req_full) begin
            take_spi_byte(req_rx_byte);
            bytes_taken++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("spi_relay_frame_crc_handler: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset match values
      send_idle_pct = 0;
      pop_stall_pct = 0;
      // addressed, good CRC, all relays on
      queue_frame({8'h1F, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h01}, 16'h0000, 1'b0);
      // addressed, bad CRC low byte: relays still load, masked to zero
      queue_frame({8'hE0, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h01}, 16'h0001, 1'b0);
      // not addressed, bad CRC high byte: relays hold
      queue_frame({8'h0A, 8'h7F, 8'hAA, 8'h55, 8'h01, 8'hFF}, 16'h8000, 1'b0);
      wait_idle();

      // Sweep match settings and idle patterns
      write_match_reg(CSR_MATCH_FIRST, 8'h00);
      write_match_reg(CSR_MATCH_SECOND, 8'h00);
      run_random_phase(0, 0, 1'b1);

      write_match_reg(CSR_MATCH_FIRST, 8'hFF);
      write_match_reg(CSR_MATCH_SECOND, 8'hFF);
      run_random_phase(84, 0, 1'b0);

      write_match_reg(CSR_UNMAPPED_LO, 8'h00);
      write_match_reg(CSR_UNMAPPED_HI, 8'hFF);
      write_match_reg(CSR_MATCH_FIRST, 8'h5A);
      write_match_reg(CSR_MATCH_SECOND, 8'hC3);
      run_random_phase(0, 84, 1'b0);

      write_match_reg(CSR_MATCH_FIRST, 8'($urandom_range(255)));
      write_match_reg(CSR_MATCH_SECOND, 8'($urandom_range(255)));
      run_random_phase(35, 35, 1'b1);

      if (echo_due.size() != 0) begin
         report_mismatch("responses never delivered", 0, echo_due.size());
      end
      if (mismatch_count == 0) begin
         $display("spi_relay_frame_crc_handler: match");
      end else begin
         $display("spi_relay_frame_crc_handler: mismatch");
      end
      $finish;
   end

endmodule
